/* src/b64d_pkg.sv */
// Package for the base64 stream decoder: queue item type, character classes,
// status codes and the alphabet lookup. No dependencies.
package b64d_pkg;

  typedef enum logic [1:0] {
    CLS_SEXTET = 2'd0,
    CLS_PAD    = 2'd1,
    CLS_BAD    = 2'd2
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [5:0]  sextet;
    logic        last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [5:0] SX_PLUS    = 6'd62;
  localparam logic [5:0] SX_SLASH   = 6'd63;
  localparam logic [5:0] SX_LOWER   = 6'd26;
  localparam logic [5:0] SX_DIGIT   = 6'd52;

  function automatic item_t classify(input logic [7:0] c, input logic last);
    item_t r;
    logic [7:0] d;
    r.last   = last;
    r.cls    = CLS_SEXTET;
    r.sextet = '0;
    d        = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d        = c - 8'h41;
      r.sextet = d[5:0];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d        = c - 8'h61;
      r.sextet = d[5:0] + SX_LOWER;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d        = c - 8'h30;
      r.sextet = d[5:0] + SX_DIGIT;
    end else if (c == CHAR_PLUS) begin
      r.sextet = SX_PLUS;
    end else if (c == CHAR_SLASH) begin
      r.sextet = SX_SLASH;
    end else if (c == CHAR_PAD) begin
      r.cls = CLS_PAD;
    end else begin
      r.cls = CLS_BAD;
    end
    return r;
  endfunction

endpackage

/* src/b64d_if.sv */
// Stream interfaces of the base64 decoder: character channel and byte channel.
// Valid/ready handshake; no dependencies.
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       is_last_char;

  modport source (output valid, output in_char, output is_last_char, input ready);
  modport sink   (input valid, input in_char, input is_last_char, output ready);
endinterface

interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       end_of_string;
  logic [1:0] status;

  modport source (output valid, output out_byte, output has_byte,
                  output end_of_string, output status, input ready);
  modport sink   (input valid, input out_byte, input has_byte,
                  input end_of_string, input status, output ready);
endinterface

/* src/b64d_front.sv */
// Front end: accepts characters and classifies them into queue items.
// Depends on b64d_pkg and b64d_char_if.
module b64d_front (
  b64d_char_if.sink     char_ch,
  input  logic          full,
  output b64d_pkg::push_t push
);
  import b64d_pkg::*;

  assign char_ch.ready = !full;

  always_comb begin
    push.valid = char_ch.valid && !full;
    push.item  = classify(char_ch.in_char, char_ch.is_last_char);
  end

endmodule

/* src/b64d_queue.sv */
// Small FIFO of classified items between front and back end.
// Depends on b64d_pkg.
module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  b64d_pkg::push_t push,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output b64d_pkg::item_t head
);
  import b64d_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  item_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push.valid && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.item;
    end
  end

endmodule

/* src/b64d_back.sv */
// Back end: group state, byte assembly, string status and output register.
// Depends on b64d_pkg and b64d_byte_if.
module b64d_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            not_empty,
  input  b64d_pkg::item_t head,
  output logic            pop,
  b64d_byte_if.source     byte_ch
);
  import b64d_pkg::*;

  logic [5:0] prev_sextet, prev_sextet_next;
  logic [1:0] group_position, group_position_next;
  logic       pad_seen, pad_seen_next;
  logic       bad_char_seen, bad_char_seen_next;
  logic [7:0] byte_val;
  logic       has_byte;
  logic       emit;
  logic [1:0] status_val;

  logic       o_valid;
  logic [7:0] o_byte;
  logic       o_has;
  logic       o_eos;
  logic [1:0] o_status;

  assign pop = not_empty && (!o_valid || byte_ch.ready);

  always_comb begin
    prev_sextet_next    = prev_sextet;
    group_position_next = group_position;
    pad_seen_next       = pad_seen;
    bad_char_seen_next  = bad_char_seen;
    byte_val            = '0;
    has_byte            = 1'b0;
    if (!pad_seen && !bad_char_seen) begin
      unique case (head.cls)
        CLS_PAD: pad_seen_next = 1'b1;
        CLS_SEXTET: begin
          unique case (group_position)
            2'd1: byte_val = {prev_sextet, head.sextet[5:4]};
            2'd2: byte_val = {prev_sextet[3:0], head.sextet[5:2]};
            2'd3: byte_val = {prev_sextet[1:0], head.sextet};
            default: byte_val = '0;
          endcase
          has_byte            = (group_position != 2'd0);
          prev_sextet_next    = head.sextet;
          group_position_next = group_position + 2'd1;
        end
        default: bad_char_seen_next = 1'b1;
      endcase
    end
    if (bad_char_seen_next) begin
      status_val = STATUS_BAD_CHAR;
    end else if (group_position_next == 2'd1) begin
      status_val = STATUS_BAD_LEN;
    end else begin
      status_val = STATUS_OK;
    end
    emit = head.last || has_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sextet    <= '0;
      group_position <= '0;
      pad_seen       <= 1'b0;
      bad_char_seen  <= 1'b0;
      o_valid        <= 1'b0;
    end else begin
      if (pop) begin
        if (head.last) begin
          prev_sextet    <= '0;
          group_position <= '0;
          pad_seen       <= 1'b0;
          bad_char_seen  <= 1'b0;
        end else begin
          prev_sextet    <= prev_sextet_next;
          group_position <= group_position_next;
          pad_seen       <= pad_seen_next;
          bad_char_seen  <= bad_char_seen_next;
        end
        o_valid <= emit;
      end else if (byte_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      o_byte   <= byte_val;
      o_has    <= has_byte;
      o_eos    <= head.last;
      o_status <= head.last ? status_val : STATUS_OK;
    end
  end

  assign byte_ch.valid         = o_valid;
  assign byte_ch.out_byte      = o_byte;
  assign byte_ch.has_byte      = o_has;
  assign byte_ch.end_of_string = o_eos;
  assign byte_ch.status        = o_status;

endmodule

/* src/base64_stream_decoder.sv */
// Top level of the streaming base64 decoder (standard alphabet, '=' pad).
// Depends on b64d_pkg, b64d_if, b64d_front, b64d_queue and b64d_back.
//
// One character per transaction enters on char_ch; is_last_char marks the
// end of a string. A byte transaction leaves on byte_ch after the second,
// third and fourth character of each group of four, and the last character
// always yields one carrying end_of_string and status (ok, invalid
// character, bad length). After the first '=' the rest of the string is
// ignored. On a nonzero status the consumer drops that string's bytes.
// Throughput is one character per cycle while byte_ch is not stalled: the
// front classifies the character through the alphabet table and writes it
// into a QUEUE_DEPTH-entry queue; the back end pops one item per cycle,
// updates the group state and loads the output register. The queue lets
// the input keep flowing for up to QUEUE_DEPTH characters while byte_ch
// is stalled. No clearing pass after reset.
module base64_stream_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  b64d_char_if.sink   char_ch,
  b64d_byte_if.source byte_ch
);
  import b64d_pkg::*;

  push_t push;
  item_t head;
  logic  full;
  logic  not_empty;
  logic  pop;

  // classify incoming characters
  b64d_front u_front (
    .char_ch (char_ch),
    .full    (full),
    .push    (push)
  );

  // decouples the input side from output stalls
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  // decode state machine and output register
  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .byte_ch   (byte_ch)
  );

endmodule

/* sim/testbench.sv */
// Self-checking testbench for base64_stream_decoder: drives characters, predicts
// each byte transaction in a scoreboard class and compares every field.
// Depends on b64d_pkg, b64d_if and the decoder RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import b64d_pkg::*;

  localparam int RANDOM_CHARS = 950;   // stimulus stops once this many were sent
  localparam int MAX_GAP      = 17;    // longest idle draw per transaction, either side
  localparam int LONG_HOLD    = 400;   // one long byte-side stall to fill the queue
  localparam int HOLD_AT      = 60;    // byte transactions taken before that stall
  localparam int IDLE_LIMIT   = 3000;  // cycles with no transaction before giving up
  localparam int TAIL_CYCLES  = 40;    // settle time once nothing is outstanding

  // One byte-channel transaction as the scoreboard sees it.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_string;
    logic [1:0] status;
  } byte_txn_t;

  // Tracks the group state of the string in flight and queues the byte
  // transactions it should produce, oldest first.
  class b64_scoreboard;
    byte_txn_t  expected_bytes[$];
    logic [5:0] held_sextet = '0;  // sextet of the previous char in the group
    logic [1:0] slot        = '0;  // alphabet chars seen before the pad, mod 4
    bit         pad_hit     = 0;
    bit         bad_hit     = 0;
    int         errors      = 0;

    // Standard alphabet lookup; returns 0 for anything outside it ('=' too).
    function bit to_sextet(input logic [7:0] c, output logic [5:0] sx);
      logic [7:0] d;
      sx = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin        // A..Z -> 0..25
        d  = c - 8'h41;
        sx = d[5:0];
      end else if (c >= 8'h61 && c <= 8'h7A) begin // a..z -> 26..51
        d  = c - 8'h61 + 8'd26;
        sx = d[5:0];
      end else if (c >= 8'h30 && c <= 8'h39) begin // 0..9 -> 52..61
        d  = c - 8'h30 + 8'd52;
        sx = d[5:0];
      end else if (c == CHAR_PLUS) begin
        sx = SX_PLUS;
      end else if (c == CHAR_SLASH) begin
        sx = SX_SLASH;
      end else begin
        return 0;
      end
      return 1;
    endfunction

    function void note_char(input logic [7:0] c, input logic last);
      logic [5:0] sx;
      byte_txn_t  r;
      r = '0;
      if (!pad_hit && !bad_hit) begin
        if (c == CHAR_PAD) begin
          pad_hit = 1;
        end else if (!to_sextet(c, sx)) begin
          bad_hit = 1;
        end else begin
          case (slot)
            2'd1: begin
              r.out_byte = {held_sextet, sx[5:4]};
              r.has_byte = 1'b1;
            end
            2'd2: begin
              r.out_byte = {held_sextet[3:0], sx[5:2]};
              r.has_byte = 1'b1;
            end
            2'd3: begin
              r.out_byte = {held_sextet[1:0], sx};
              r.has_byte = 1'b1;
            end
            default: ;
          endcase
          held_sextet = sx;
          slot        = slot + 2'd1;
        end
      end
      if (last) begin
        r.end_of_string = 1'b1;
        if (bad_hit)
          r.status = STATUS_BAD_CHAR;  // wins over a short group
        else if (slot == 2'd1)
          r.status = STATUS_BAD_LEN;
        else
          r.status = STATUS_OK;
        held_sextet = '0;
        slot        = '0;
        pad_hit     = 0;
        bad_hit     = 0;
      end
      if (last || r.has_byte)
        expected_bytes.push_back(r);
    endfunction

    function void compare_field(input string field, input int want, input int got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_byte(input byte_txn_t got);
      byte_txn_t want;
      if (expected_bytes.size() == 0) begin
        $error("byte transaction with nothing expected: byte %0d has %0d eos %0d status %0d",
               got.out_byte, got.has_byte, got.end_of_string, got.status);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      compare_field("out_byte", int'(want.out_byte), int'(got.out_byte));
      compare_field("has_byte", int'(want.has_byte), int'(got.has_byte));
      compare_field("end_of_string", int'(want.end_of_string), int'(got.end_of_string));
      compare_field("status", int'(want.status), int'(got.status));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  b64d_char_if char_ch ();
  b64d_byte_if byte_ch ();

  base64_stream_decoder u_dut (
    .clk     (clk),
    .rst     (rst),
    .char_ch (char_ch),
    .byte_ch (byte_ch)
  );

  always #1 clk = ~clk;

  b64_scoreboard sb;
  logic [7:0]    text[$];     // characters of the next string to send
  int            chars_sent;
  int            bytes_taken;
  bit            tx_burst;    // sender runs back to back for this string
  bit            rx_burst;    // receiver never stalls for this stretch
  int            idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // Character side
  // ---------------------------------------------------------------------------

  // One character transaction. valid stays high between back-to-back
  // characters so it never gets two updates in one step.
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      char_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_ch.valid        <= 1'b1;
    char_ch.in_char      <= c;
    char_ch.is_last_char <= last;
    do @(posedge clk); while (!char_ch.ready);
    sb.note_char(c, last);
    chars_sent++;
  endtask

  // Sends the whole string held in text, flagging its final character.
  task automatic send_text();
    tx_burst = ($urandom_range(0, 3) == 0);
    foreach (text[k])
      send_char(text[k], k == text.size() - 1);
    text.delete();
  endtask

  function automatic void add_text(input string s);
    for (int k = 0; k < s.len(); k++)
      text.push_back(s[k]);
  endfunction

  function automatic logic [7:0] alpha_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) return w + 8'h41;                 // A..Z
    if (v < SX_DIGIT) return w - 8'd26 + 8'h61;      // a..z
    if (v < SX_PLUS) return w - 8'd52 + 8'h30;       // 0..9
    return (v == SX_PLUS) ? CHAR_PLUS : CHAR_SLASH;
  endfunction

  // Mostly well-formed strings with random content; the rest are short
  // groups, junk after the pad, raw noise and strings with one bad char.
  function automatic void build_random_text();
    int kind;
    int nbytes;
    int nchars;
    int pos;
    kind = $urandom_range(0, 9);
    text.delete();
    case (kind)
      7: begin
        nchars = 4 * $urandom_range(0, 2) + 1;       // one char left over
        for (int k = 0; k < nchars; k++)
          text.push_back(alpha_char(6'($urandom_range(0, 63))));
        if ($urandom_range(0, 1) == 1)
          text.push_back(CHAR_PAD);
      end
      8: begin
        nchars = $urandom_range(1, 8);
        for (int k = 0; k < nchars; k++)
          text.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        nbytes = $urandom_range(1, 12);
        nchars = (nbytes * 4 + 2) / 3;
        for (int k = 0; k < nchars; k++)
          text.push_back(alpha_char(6'($urandom_range(0, 63))));
        if ($urandom_range(0, 3) != 0) begin
          while (text.size() % 4 != 0)
            text.push_back(CHAR_PAD);
        end
        if (kind == 6) begin
          nchars = $urandom_range(1, 4);
          for (int k = 0; k < nchars; k++)
            text.push_back(8'($urandom_range(0, 255)));
        end else if (kind == 9) begin
          pos       = $urandom_range(0, text.size() - 1);
          text[pos] = 8'($urandom_range(0, 255));
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Byte side: random stalls, burst stretches and one long hold-off while the
  // character side keeps offering, so the queue fills and input backs up.
  // ---------------------------------------------------------------------------
  task automatic collect_bytes();
    int        gap;
    byte_txn_t got;
    forever begin
      if (bytes_taken % 32 == 0)
        rx_burst = ($urandom_range(0, 2) == 0);
      gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (bytes_taken == HOLD_AT)
        gap = LONG_HOLD;
      if (gap > 0) begin
        byte_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      byte_ch.ready <= 1'b1;
      do @(posedge clk); while (!byte_ch.valid);
      got.out_byte      = byte_ch.out_byte;
      got.has_byte      = byte_ch.has_byte;
      got.end_of_string = byte_ch.end_of_string;
      got.status        = byte_ch.status;
      sb.check_byte(got);
      bytes_taken++;
    end
  endtask

  initial begin
    byte_ch.ready = 1'b0;
    bytes_taken   = 0;
    rx_burst      = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    collect_bytes();
  end

  // Watchdog: a stretch with no transaction on either side means a hang.
  always @(posedge clk) begin
    if (rst || (char_ch.valid && char_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    sb                   = new();
    chars_sent           = 0;
    tx_burst             = 0;
    char_ch.valid        = 1'b0;
    char_ch.in_char      = '0;
    char_ch.is_last_char = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed strings: a full group, pad after two chars with a pad as the
    // last char, a lone char (bad length), alphabet edges, junk after the
    // pad, and a bad char that suppresses later bytes and beats bad length.
    add_text("TWFu");
    send_text();
    add_text("TQ==");
    send_text();
    add_text("Q");
    send_text();
    add_text("az09");
    send_text();
    add_text("+/AZ");
    send_text();
    add_text("AZ=");
    text.push_back(8'hFF);
    send_text();
    add_text("A");
    text.push_back(8'h00);
    add_text("QQ");
    send_text();

    while (chars_sent < RANDOM_CHARS) begin
      build_random_text();
      send_text();
    end
    char_ch.valid <= 1'b0;

    // Wait out everything still in flight; the watchdog catches a loss.
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.expected_bytes.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
src/b64d_pkg.sv
src/b64d_if.sv
src/b64d_front.sv
src/b64d_queue.sv
src/b64d_back.sv
src/base64_stream_decoder.sv
sim/testbench.sv
